### hdl/sprite_frame_time_lookup_core_defines.svh
// Assertion macros shared by the sprite frame time lookup modules.
`ifndef SPRITE_FRAME_TIME_LOOKUP_CORE_DEFINES_SVH
`define SPRITE_FRAME_TIME_LOOKUP_CORE_DEFINES_SVH

// check a property at every clock edge outside reset
`define SFTL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a same-cycle implication
`define SFTL_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check a next-cycle implication
`define SFTL_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sftl_pkg.sv
// Types, constants and helpers for the sprite frame time lookup core.
package sftl_pkg;

  localparam int unsigned MAX_FRAMES_DEF      = 64;
  localparam int unsigned SPEED_FRAC_BITS_DEF = 8;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned PROD_W  = TIME_W + SPEED_W;
  localparam int unsigned CFG_W   = SPEED_W;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

  localparam logic [1:0] OVR_FORCE_OFF = 2'd1;
  localparam logic [1:0] OVR_FORCE_ON  = 2'd2;

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CFG_LOOP_ENABLE = 2'd0,
    CFG_SPEED       = 2'd1,
    CFG_FLIP_X_OVR  = 2'd2,
    CFG_FLIP_Y_OVR  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_DIV,
    ST_SEARCH,
    ST_LAST
  } state_e;

  typedef struct packed {
    logic               func;
    logic [23:0]        frame_time;
    logic               frame_flip_x;
    logic               frame_flip_y;
    logic signed [31:0] elapsed_time;
    logic [5:0]         start_frame;
  } sftl_in_t;

  typedef struct packed {
    logic        frame_valid;
    logic [5:0]  frame_index;
    logic        out_flip_x;
    logic        out_flip_y;
    logic [6:0]  frame_count;
    logic [31:0] total_time;
    logic        status;
  } sftl_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] end_time;
    logic              flip_y;
    logic              flip_x;
  } frame_entry_t;

  function automatic logic apply_ovr(input logic [1:0] ovr, input logic frame_bit);
    logic r;
    r = frame_bit;
    if (ovr == OVR_FORCE_OFF) r = 1'b0;
    if (ovr == OVR_FORCE_ON)  r = 1'b1;
    return r;
  endfunction

endpackage

### hdl/sftl_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`include "sprite_frame_time_lookup_core_defines.svh"

module sftl_rem #(
  parameter int unsigned DVD_W = sftl_pkg::PROD_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [DVD_W-1:0]               dividend_i,
  input  logic [sftl_pkg::TIME_W-1:0]    divisor_i,
  output logic                           done_o,
  output logic [sftl_pkg::TIME_W-1:0]    rem_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam int unsigned TW    = sftl_pkg::TIME_W;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [TW-1:0]    div_q, div_d;
  logic [TW-1:0]    rem_q, rem_d;
  logic [TW:0]      trial;
  logic [TW:0]      diff;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, div_q}) ? diff[TW-1:0] : trial[TW-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `SFTL_IMPLY(a_rem_below_div, done_q, rem_q < div_q, "remainder not below divisor")
  `SFTL_IMPLY(a_busy_cnt, busy_q, cnt_q != '0, "busy with zero step count")
  `SFTL_IMPLY(a_no_restart, start_i, !busy_q, "restart while busy")

endmodule

### hdl/sprite_frame_time_lookup_core.sv
// Sprite frame time lookup core: frame table in memory, append and time query.
//
//   channel   handshake              payload
//   ------    ---------------------  -------------------------------
//   input     start_i && !busy_o     data_i   (sftl_pkg::sftl_in_t)
//   result    done_o, one cycle      result_o (sftl_pkg::sftl_out_t)
//   config    cfg_we_i               cfg_idx_i, cfg_data_i
//
// Append and rejected queries: result in the cycle after the transfer.
// Query: the search walks the frame memory one entry per cycle, from the start frame or,
// when the time wraps, from entry 0 after the bit-serial remainder unit has reduced it.
// Reset clears frame count and total and sets the config registers to their reset values;
// the frame memory is not cleared. The receiver cannot stall; each result shows for exactly one cycle.
`include "sprite_frame_time_lookup_core_defines.svh"

module sprite_frame_time_lookup_core #(
  parameter int unsigned MAX_FRAMES      = sftl_pkg::MAX_FRAMES_DEF,
  parameter int unsigned SPEED_FRAC_BITS = sftl_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  sftl_pkg::sftl_in_t          data_i,
  output logic                        done_o,
  output sftl_pkg::sftl_out_t         result_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [sftl_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned TW     = sftl_pkg::TIME_W;
  localparam int unsigned PW     = sftl_pkg::PROD_W;
  localparam int unsigned T_W    = PW - SPEED_FRAC_BITS;
  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  sftl_pkg::state_e state_q, state_d;

  logic                        loop_q;
  logic [sftl_pkg::SPEED_W-1:0] speed_q;
  logic [1:0]                  ovr_x_q, ovr_y_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [TW-1:0]    total_q, total_d;
  logic [T_W-1:0]   t_q, t_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [5:0]       start_q, start_d;

  sftl_pkg::sftl_out_t res_q, res_d;
  logic                done_q, done_d;

  sftl_pkg::frame_entry_t mem [MAX_FRAMES];
  sftl_pkg::frame_entry_t rd_data_q;
  sftl_pkg::frame_entry_t wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;

  logic             rem_start;
  logic             rem_done;
  logic [TW-1:0]    rem_val;

  logic             accept;
  logic             is_query;
  logic             q_reject;
  logic             table_full;
  logic [TW:0]      sum;
  logic [TW-1:0]    sum_sat;
  logic [TW-1:0]    mag;
  logic [PW-1:0]    prod;
  logic             wrap_hit;
  logic             hit;
  logic             at_last;
  logic             start_past;
  logic [IDX_W-1:0] last_idx;

  assign accept     = start_i && (state_q == sftl_pkg::ST_IDLE);
  assign is_query   = (data_i.func == sftl_pkg::FUNC_QUERY);
  assign q_reject   = (data_i.elapsed_time[TW-1] && (speed_q != '0)) || (count_q == '0);
  assign table_full = (count_q >= CNT_W'(MAX_FRAMES));
  assign sum        = {1'b0, total_q} + (TW + 1)'(data_i.frame_time);
  assign sum_sat    = sum[TW] ? '1 : sum[TW-1:0];
  assign mag        = data_i.elapsed_time[TW-1] ? '0 : TW'(data_i.elapsed_time);
  assign prod       = PW'(mag) * PW'(speed_q);
  assign wrap_hit   = loop_q && (t_q >= T_W'(total_q));
  assign hit        = (t_q <= T_W'(rd_data_q.end_time));
  assign at_last    = ((CNT_W'(idx_q) + 1'b1) >= count_q);
  assign start_past = (32'(start_q) >= 32'(count_q));
  assign last_idx   = IDX_W'(count_q - 1'b1);

  assign wr_data.end_time = sum_sat;
  assign wr_data.flip_x   = data_i.frame_flip_x;
  assign wr_data.flip_y   = data_i.frame_flip_y;

  sftl_rem #(
    .DVD_W (T_W)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (t_q),
    .divisor_i  (total_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sftl_pkg::ST_IDLE: begin
        if (accept && is_query && !q_reject) state_d = sftl_pkg::ST_WRAP;
      end
      sftl_pkg::ST_WRAP: begin
        if (wrap_hit) begin
          state_d = (total_q == '0) ? sftl_pkg::ST_LAST : sftl_pkg::ST_DIV;
        end else begin
          state_d = start_past ? sftl_pkg::ST_LAST : sftl_pkg::ST_SEARCH;
        end
      end
      sftl_pkg::ST_DIV: begin
        if (rem_done) state_d = sftl_pkg::ST_SEARCH;
      end
      sftl_pkg::ST_SEARCH: begin
        if (hit || at_last) state_d = sftl_pkg::ST_IDLE;
      end
      sftl_pkg::ST_LAST: begin
        state_d = sftl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d   = count_q;
    total_d   = total_q;
    t_d       = t_q;
    idx_d     = idx_q;
    start_d   = start_q;
    res_d     = res_q;
    done_d    = 1'b0;
    rd_addr   = idx_q;
    mem_we    = 1'b0;
    rem_start = 1'b0;
    unique case (state_q)
      sftl_pkg::ST_IDLE: begin
        if (accept) begin
          t_d     = T_W'(prod >> SPEED_FRAC_BITS);
          start_d = data_i.start_frame;
          res_d   = '0;
          if (!is_query) begin
            done_d = 1'b1;
            if (table_full) begin
              res_d.status = 1'b1;
            end else begin
              mem_we  = 1'b1;
              total_d = sum_sat;
              count_d = count_q + 1'b1;
            end
            res_d.frame_count = 7'(count_d);
            res_d.total_time  = total_d;
          end else if (q_reject) begin
            done_d            = 1'b1;
            res_d.frame_count = 7'(count_q);
            res_d.total_time  = total_q;
          end
        end
      end
      sftl_pkg::ST_WRAP: begin
        if (wrap_hit) begin
          if (total_q == '0) begin
            rd_addr = last_idx;
          end else begin
            rem_start = 1'b1;
          end
        end else if (start_past) begin
          rd_addr = last_idx;
        end else begin
          idx_d   = IDX_W'(start_q);
          rd_addr = IDX_W'(start_q);
        end
      end
      sftl_pkg::ST_DIV: begin
        if (rem_done) begin
          t_d     = T_W'(rem_val);
          idx_d   = '0;
          rd_addr = '0;
        end
      end
      sftl_pkg::ST_SEARCH: begin
        if (hit || at_last) begin
          done_d            = 1'b1;
          res_d.frame_valid = 1'b1;
          res_d.frame_index = 6'(idx_q);
          res_d.out_flip_x  = sftl_pkg::apply_ovr(ovr_x_q, rd_data_q.flip_x);
          res_d.out_flip_y  = sftl_pkg::apply_ovr(ovr_y_q, rd_data_q.flip_y);
          res_d.frame_count = 7'(count_q);
          res_d.total_time  = total_q;
        end else begin
          idx_d   = idx_q + 1'b1;
          rd_addr = idx_q + 1'b1;
        end
      end
      sftl_pkg::ST_LAST: begin
        done_d            = 1'b1;
        res_d.frame_valid = 1'b1;
        res_d.frame_index = 6'(last_idx);
        res_d.out_flip_x  = sftl_pkg::apply_ovr(ovr_x_q, rd_data_q.flip_x);
        res_d.out_flip_y  = sftl_pkg::apply_ovr(ovr_y_q, rd_data_q.flip_y);
        res_d.frame_count = 7'(count_q);
        res_d.total_time  = total_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sftl_pkg::ST_IDLE;
      count_q <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
      loop_q  <= 1'b0;
      speed_q <= sftl_pkg::SPEED_RESET;
      ovr_x_q <= '0;
      ovr_y_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sftl_pkg::CFG_LOOP_ENABLE: loop_q  <= cfg_data_i[0];
          sftl_pkg::CFG_SPEED:       speed_q <= cfg_data_i;
          sftl_pkg::CFG_FLIP_X_OVR:  ovr_x_q <= cfg_data_i[1:0];
          sftl_pkg::CFG_FLIP_Y_OVR:  ovr_y_q <= cfg_data_i[1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    idx_q   <= idx_d;
    start_q <= start_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IDX_W-1:0]] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign busy_o   = (state_q != sftl_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `SFTL_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_FRAMES), "frame count above table size")
  `SFTL_IMPLY(a_search_idx, state_q == sftl_pkg::ST_SEARCH, CNT_W'(idx_q) < count_q,
    "search index past stored frames")
  `SFTL_IMPLY(a_valid_nonempty, done_q && res_q.frame_valid, count_q != '0,
    "frame selected from an empty table")
  `SFTL_NEXT(a_append_count, accept && !is_query && !table_full,
    count_q == CNT_W'($past(count_q) + 1'b1), "append did not advance frame count")

endmodule

### dv/tb_top.sv
// Self-checking testbench for the sprite frame time lookup core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned N_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS = 102;
  localparam int unsigned TABLE_DEPTH = sftl_pkg::MAX_FRAMES_DEF;

  logic                        clk_i      = 1'b0;
  logic                        rst_ni     = 1'b0;
  logic                        start_i    = 1'b0;
  logic                        busy_o;
  sftl_pkg::sftl_in_t          data_i     = '0;
  logic                        done_o;
  sftl_pkg::sftl_out_t         result_o;
  logic                        cfg_we_i   = 1'b0;
  logic [1:0]                  cfg_idx_i  = sftl_pkg::CFG_LOOP_ENABLE;
  logic [sftl_pkg::CFG_W-1:0]  cfg_data_i = '0;

  sprite_frame_time_lookup_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .data_i     (data_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // frame table shadow and register shadow
  logic [31:0]  tbl_end [TABLE_DEPTH];
  logic         tbl_fx  [TABLE_DEPTH];
  logic         tbl_fy  [TABLE_DEPTH];
  int unsigned  tbl_count = 0;
  logic [31:0]  tbl_total = '0;
  logic         reg_loop  = 1'b0;
  logic [15:0]  reg_speed = sftl_pkg::SPEED_RESET;
  logic [1:0]   reg_ovr_x = '0;
  logic [1:0]   reg_ovr_y = '0;

  // stimulus planning view of the table
  int unsigned  plan_count = 0;
  longint unsigned plan_total = 0;

  sftl_pkg::sftl_in_t   pending_items[$];
  sftl_pkg::sftl_out_t  expected_results[$];
  int unsigned  idle_pct = 25;
  bit           took = 1'b0;
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  n_append = 0, n_dropped = 0, n_query = 0, n_hit = 0, n_wrap = 0, n_none = 0;

  function automatic logic eff_flip(logic [1:0] ovr, logic frame_bit);
    if (ovr == sftl_pkg::OVR_FORCE_OFF) return 1'b0;
    if (ovr == sftl_pkg::OVR_FORCE_ON) return 1'b1;
    return frame_bit;
  endfunction

  function automatic sftl_pkg::sftl_out_t lookup_frame(sftl_pkg::sftl_in_t it);
    sftl_pkg::sftl_out_t r;
    logic [63:0] t;
    logic [63:0] mag;
    logic [63:0] sum;
    int unsigned idx;
    bit force_last;
    r = '0;
    if (it.func == sftl_pkg::FUNC_APPEND) begin
      n_append++;
      if (tbl_count >= TABLE_DEPTH) begin
        r.status = 1'b1;
        n_dropped++;
      end else begin
        sum = {32'd0, tbl_total} + {40'd0, it.frame_time};
        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
        tbl_total = sum[31:0];
        tbl_end[tbl_count] = tbl_total;
        tbl_fx[tbl_count]  = it.frame_flip_x;
        tbl_fy[tbl_count]  = it.frame_flip_y;
        tbl_count++;
      end
    end else begin
      n_query++;
      if (!(it.elapsed_time[31] && reg_speed != 0) && tbl_count != 0) begin
        mag = it.elapsed_time[31] ? 64'd0 : {32'd0, it.elapsed_time};
        t = (mag * {48'd0, reg_speed}) >> sftl_pkg::SPEED_FRAC_BITS_DEF;
        idx = 32'(it.start_frame);
        force_last = 1'b0;
        if (reg_loop && t >= {32'd0, tbl_total}) begin
          n_wrap++;
          if (tbl_total == 0) force_last = 1'b1;
          else t = t % {32'd0, tbl_total};
          idx = 0;
        end
        if (force_last) begin
          idx = tbl_count;
        end else begin
          while (idx < tbl_count && t > {32'd0, tbl_end[idx]}) idx++;
        end
        if (idx >= tbl_count) idx = tbl_count - 1;
        r.frame_valid = 1'b1;
        r.frame_index = idx[5:0];
        r.out_flip_x  = eff_flip(reg_ovr_x, tbl_fx[idx]);
        r.out_flip_y  = eff_flip(reg_ovr_y, tbl_fy[idx]);
        n_hit++;
      end else begin
        n_none++;
      end
    end
    r.frame_count = tbl_count[6:0];
    r.total_time  = tbl_total;
    return r;
  endfunction

  task automatic report_error(string msg);
    errors++;
    $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // result monitor and acceptance tracking
  always @(posedge clk_i) begin
    sftl_pkg::sftl_out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_error("result with no pending transfer");
        end else begin
          want = expected_results.pop_front();
          check_field("frame_valid", 32'(result_o.frame_valid), 32'(want.frame_valid));
          check_field("frame_index", 32'(result_o.frame_index), 32'(want.frame_index));
          check_field("out_flip_x", 32'(result_o.out_flip_x), 32'(want.out_flip_x));
          check_field("out_flip_y", 32'(result_o.out_flip_y), 32'(want.out_flip_y));
          check_field("frame_count", 32'(result_o.frame_count), 32'(want.frame_count));
          check_field("total_time", result_o.total_time, want.total_time);
          check_field("status", 32'(result_o.status), 32'(want.status));
        end
      end
      if (start_i && !busy_o) begin
        expected_results = {expected_results, lookup_frame(data_i)};
        took = 1'b1;
      end
    end
  end

  // command driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || took) begin
      took = 1'b0;
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start_i <= 1'b1;
        data_i  <= pending_items.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sprite_frame_time_lookup_core");
      $finish;
    end
  end

  function automatic sftl_pkg::sftl_in_t random_item();
    logic [95:0] raw;
    sftl_pkg::sftl_in_t it;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(sftl_pkg::sftl_in_t)-1:0];
    return it;
  endfunction

  task automatic push_item(sftl_pkg::sftl_in_t it);
    if (it.func == sftl_pkg::FUNC_APPEND && plan_count < TABLE_DEPTH) begin
      plan_count++;
      plan_total += 64'(it.frame_time);
    end
    pending_items = {pending_items, it};
  endtask

  task automatic push_append(logic [23:0] ft, logic fx, logic fy);
    sftl_pkg::sftl_in_t it;
    it = random_item();
    it.func         = sftl_pkg::FUNC_APPEND;
    it.frame_time   = ft;
    it.frame_flip_x = fx;
    it.frame_flip_y = fy;
    push_item(it);
  endtask

  task automatic push_query(logic [31:0] elapsed, logic [5:0] first);
    sftl_pkg::sftl_in_t it;
    it = random_item();
    it.func         = sftl_pkg::FUNC_QUERY;
    it.elapsed_time = elapsed;
    it.start_frame  = first;
    push_item(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || start_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(sftl_pkg::cfg_reg_e idx, logic [sftl_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      sftl_pkg::CFG_LOOP_ENABLE: reg_loop  = value[0];
      sftl_pkg::CFG_SPEED:       reg_speed = value;
      sftl_pkg::CFG_FLIP_X_OVR:  reg_ovr_x = value[1:0];
      sftl_pkg::CFG_FLIP_Y_OVR:  reg_ovr_y = value[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] elapsed_for(longint unsigned t);
    longint unsigned e;
    if (reg_speed == 0) return $urandom;
    e = (t << sftl_pkg::SPEED_FRAC_BITS_DEF) / reg_speed;
    if (e > 64'h7FFF_FFFF) e = 64'h7FFF_FFFF;
    return e[31:0];
  endfunction

  task automatic random_phase(int unsigned n, int unsigned append_pct);
    int unsigned r;
    longint unsigned span;
    logic [23:0] ft;
    logic [5:0] first;
    logic [31:0] e;
    repeat (n) begin
      if ($urandom_range(99) < append_pct) begin
        r = $urandom_range(99);
        if (r < 20) ft = '0;
        else if (r < 30) ft = 24'($urandom);
        else if (r < 33) ft = 24'hFF_FFFF;
        else ft = 24'($urandom_range(2000, 1));
        push_append(ft, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        r = $urandom_range(99);
        if (r < 50) first = '0;
        else if (r < 80 && plan_count > 0) first = 6'($urandom_range(plan_count - 1));
        else first = 6'($urandom_range(63));
        r = $urandom_range(99);
        span = 2 * plan_total + 3;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        if (r < 60) e = elapsed_for(64'($urandom_range(span[31:0])));
        else if (r < 75) e = {1'b1, 31'($urandom)};
        else e = $urandom;
        push_query(e, first);
      end
    end
  endtask

  initial begin
    logic [15:0] phase_speed [N_PHASES];
    phase_speed = '{16'd256, 16'd65535, 16'd1, 16'd0, 16'd128,
                    16'd512, 16'($urandom), 16'd256, 16'd4096, 16'($urandom)};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_query(32'd5, 6'd0);
    push_append(24'd0, 1'b1, 1'b0);
    push_query(32'd0, 6'd0);
    wait_idle();
    write_reg(sftl_pkg::CFG_LOOP_ENABLE, 16'd1);
    push_query(32'd10, 6'd0);
    push_append(24'hFF_FFFF, 1'b0, 1'b1);
    push_append(24'd1, 1'b1, 1'b1);
    push_append(24'd100, 1'b0, 1'b0);
    push_query(32'h7FFF_FFFF, 6'd3);
    push_query(32'hFFFF_FFFF, 6'd0);
    push_query(32'h8000_0000, 6'd0);
    wait_idle();
    write_reg(sftl_pkg::CFG_SPEED, 16'd0);
    push_query(32'hFFFF_FFFB, 6'd2);
    push_query(32'h7FFF_FFFF, 6'd1);
    wait_idle();
    write_reg(sftl_pkg::CFG_LOOP_ENABLE, 16'd0);
    write_reg(sftl_pkg::CFG_SPEED, 16'hFFFF);
    write_reg(sftl_pkg::CFG_FLIP_X_OVR, 16'(sftl_pkg::OVR_FORCE_ON));
    write_reg(sftl_pkg::CFG_FLIP_Y_OVR, 16'(sftl_pkg::OVR_FORCE_OFF));
    push_query(32'h7FFF_FFFF, 6'd0);
    push_query(32'd0, 6'd63);
    push_query(32'd0, 6'd2);
    wait_idle();
    write_reg(sftl_pkg::CFG_FLIP_X_OVR, 16'(sftl_pkg::OVR_FORCE_OFF));
    write_reg(sftl_pkg::CFG_FLIP_Y_OVR, 16'(sftl_pkg::OVR_FORCE_ON));
    push_query(32'd300, 6'd0);
    wait_idle();
    write_reg(sftl_pkg::CFG_FLIP_X_OVR, 16'd3);
    write_reg(sftl_pkg::CFG_FLIP_Y_OVR, 16'd3);
    push_query(32'd1, 6'd1);
    push_query(32'd0, 6'd0);
    wait_idle();

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      write_reg(sftl_pkg::CFG_LOOP_ENABLE, 16'(p[0] ^ (p > 4)));
      write_reg(sftl_pkg::CFG_SPEED, phase_speed[p]);
      write_reg(sftl_pkg::CFG_FLIP_X_OVR, 16'($urandom_range(3)));
      write_reg(sftl_pkg::CFG_FLIP_Y_OVR, 16'($urandom_range(3)));
      idle_pct = (p == 3) ? 0 : 25;
      random_phase(PHASE_ITEMS / 2, (p == N_PHASES - 1) ? 30 : 8);
      wait_idle();
      random_phase(PHASE_ITEMS - PHASE_ITEMS / 2, (p == N_PHASES - 1) ? 30 : 8);
      wait_idle();
    end

    repeat (150) @(posedge clk_i);
    $display("Covered %0d appends (%0d dropped on a full table) and %0d queries",
             n_append, n_dropped, n_query);
    $display("Queries: %0d selected a frame, %0d wrapped, %0d gave no frame",
             n_hit, n_wrap, n_none);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS sprite_frame_time_lookup_core");
    end else begin
      $display("FAIL sprite_frame_time_lookup_core");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/sftl_pkg.sv
hdl/sftl_rem.sv
hdl/sprite_frame_time_lookup_core.sv
dv/tb_top.sv
